[sv/s1md_pkg.sv]
package s1md_pkg;

    // Initial chaining words
    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    // Round constants, one per group of twenty rounds
    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam int unsigned WORDS  = 16;
    localparam int unsigned ROUNDS = 80;

    // Control of the message schedule window
    typedef struct packed {
        logic load_byte;  // shift one message or pad byte in
        logic round;      // advance the schedule by one round
        logic expand;     // round 16 or later: form a new word
    } t_win_ctl;

endpackage

[sv/s1md_window.sv]
module s1md_window import s1md_pkg::*; (
    input  logic        i_clk,
    input  t_win_ctl    i_ctl,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_w
);

    logic [31:0] r_win [WORDS];
    logic [31:0] l_mix;

    assign l_mix = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
    assign o_w   = i_ctl.expand ? {l_mix[30:0], l_mix[31]} : r_win[0];

    // Bytes enter big-endian at the tail; rounds shift the line by a word.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_byte) begin
            for (int i = 0; i < WORDS - 1; i++) begin
                r_win[i] <= {r_win[i][23:0], r_win[i + 1][31:24]};
            end
            r_win[WORDS - 1] <= {r_win[WORDS - 1][23:0], i_byte};
        end else if (i_ctl.round) begin
            for (int i = 0; i < WORDS - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[WORDS - 1] <= o_w;
        end
    end

endmodule

[sv/sha1_message_digest_unit.sv]
// A byte transaction is taken while idle; the 64th byte of a block starts compression
// (80 rounds on one shared round adder, then one chaining add) and stalls the input.
// A closing transaction pads one byte a cycle to the block end, then compresses,
// padding and compressing an extra block when the length spills over.
// The single round unit limits the block rate: no byte is taken while a block compresses.
// Reset (synchronous, active low) restores the initial chaining words, clears the count.
module sha1_message_digest_unit import s1md_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word0,
    output logic [31:0] o_digest_word1,
    output logic [31:0] o_digest_word2,
    output logic [31:0] o_digest_word3,
    output logic [31:0] o_digest_word4
);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // take transactions
    localparam logic [2:0] S_ROUND = 3'd1;  // one compression round per cycle
    localparam logic [2:0] S_ADD   = 3'd2;  // fold round words into the chain
    localparam logic [2:0] S_PAD   = 3'd3;  // shift in one pad byte per cycle
    localparam logic [2:0] S_FIN   = 3'd4;  // hand the digest to the output register

    localparam logic [6:0] LAST_ROUND  = 7'(ROUNDS - 1);
    localparam logic [6:0] FIRST_EXP   = 7'(WORDS);
    localparam logic [5:0] LAST_POS    = 6'd63;
    localparam logic [5:0] LEN_POS     = 6'd56;

    logic [2:0]  r_state, n_state;
    logic [6:0]  r_round, n_round;
    logic [5:0]  r_pos,   n_pos;
    logic [60:0] r_count, n_count;
    logic [31:0] r_h0, r_h1, r_h2, r_h3, r_h4;
    logic [31:0] n_h0, n_h1, n_h2, n_h3, n_h4;
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] n_a, n_b, n_c, n_d, n_e;
    logic        r_first, n_first;      // next pad byte is the 0x80 marker
    logic        r_in_pad, n_in_pad;    // message closed, padding under way
    logic        r_len_blk, n_len_blk;  // this block carries the bit length
    logic        r_final, n_final;      // compression under way is the last one
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_dig0, r_dig1, r_dig2, r_dig3, r_dig4;
    logic        n_dig_load;

    t_win_ctl    l_win_ctl;
    logic [7:0]  l_byte;
    logic [31:0] l_w;
    logic [31:0] l_f, l_k, l_sum;
    logic [63:0] l_len_sh;
    logic [7:0]  l_pad_byte;

    s1md_window u_window (
        .i_clk  (i_clk),
        .i_ctl  (l_win_ctl),
        .i_byte (l_byte),
        .o_w    (l_w)
    );

    // Round function and constant by group of twenty
    always_comb begin
        if (r_round < 7'd20) begin
            l_f = (r_b & r_c) | (~r_b & r_d);
            l_k = K_R0;
        end else if (r_round < 7'd40) begin
            l_f = r_b ^ r_c ^ r_d;
            l_k = K_R1;
        end else if (r_round < 7'd60) begin
            l_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            l_k = K_R2;
        end else begin
            l_f = r_b ^ r_c ^ r_d;
            l_k = K_R3;
        end
    end

    assign l_sum = {r_a[26:0], r_a[31:27]} + l_f + r_e + l_k + l_w;

    // Length bytes go out most significant first at positions 56 to 63
    assign l_len_sh = {r_count, 3'b000} << {r_pos[2:0], 3'b000};

    always_comb begin
        if (r_first) begin
            l_pad_byte = PAD_BYTE;
        end else if (r_len_blk && (r_pos >= LEN_POS)) begin
            l_pad_byte = l_len_sh[63:56];
        end else begin
            l_pad_byte = 8'h00;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_pos       = r_pos;
        n_count     = r_count;
        n_h0 = r_h0; n_h1 = r_h1; n_h2 = r_h2; n_h3 = r_h3; n_h4 = r_h4;
        n_a  = r_a;  n_b  = r_b;  n_c  = r_c;  n_d  = r_d;  n_e  = r_e;
        n_first     = r_first;
        n_in_pad    = r_in_pad;
        n_len_blk   = r_len_blk;
        n_final     = r_final;
        n_dig_load  = 1'b0;
        l_win_ctl   = '0;
        l_byte      = i_data_byte;

        // drop the result once the downstream side takes it
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_end_of_message) begin
                        n_in_pad = 1'b1;
                        n_first  = 1'b1;
                        n_state  = S_PAD;
                    end
                    if (i_has_byte) begin
                        l_win_ctl.load_byte = 1'b1;
                        n_count = r_count + 61'd1;
                        n_pos   = r_pos + 6'd1;
                        if (r_pos == LAST_POS) begin
                            // block full: start compression, pad afterwards if closed
                            n_a = r_h0; n_b = r_h1; n_c = r_h2; n_d = r_h3; n_e = r_h4;
                            n_round = '0;
                            n_final = 1'b0;
                            n_state = S_ROUND;
                        end
                    end
                end
            end
            S_ROUND: begin
                l_win_ctl.round  = 1'b1;
                l_win_ctl.expand = (r_round >= FIRST_EXP);
                n_e = r_d;
                n_d = r_c;
                n_c = {r_b[1:0], r_b[31:2]};
                n_b = r_a;
                n_a = l_sum;
                if (r_round == LAST_ROUND) begin
                    n_state = S_ADD;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            S_ADD: begin
                n_h0 = r_h0 + r_a;
                n_h1 = r_h1 + r_b;
                n_h2 = r_h2 + r_c;
                n_h3 = r_h3 + r_d;
                n_h4 = r_h4 + r_e;
                if (r_final) begin
                    n_state = S_FIN;
                end else if (r_in_pad) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD: begin
                l_win_ctl.load_byte = 1'b1;
                l_byte = l_pad_byte;
                n_pos  = r_pos + 6'd1;
                if (r_first) begin
                    // the length fits behind the marker only below position 56
                    n_first   = 1'b0;
                    n_len_blk = (r_pos < LEN_POS);
                end
                if (r_pos == LAST_POS) begin
                    n_a = r_h0; n_b = r_h1; n_c = r_h2; n_d = r_h3; n_e = r_h4;
                    n_round   = '0;
                    n_final   = r_len_blk && !r_first;
                    n_len_blk = 1'b1;
                    n_state   = S_ROUND;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_dig_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_h0 = H0_INIT; n_h1 = H1_INIT; n_h2 = H2_INIT;
                    n_h3 = H3_INIT; n_h4 = H4_INIT;
                    n_count   = '0;
                    n_pos     = '0;
                    n_first   = 1'b0;
                    n_in_pad  = 1'b0;
                    n_len_blk = 1'b0;
                    n_final   = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_round     <= '0;
            r_pos       <= '0;
            r_count     <= '0;
            r_h0        <= H0_INIT;
            r_h1        <= H1_INIT;
            r_h2        <= H2_INIT;
            r_h3        <= H3_INIT;
            r_h4        <= H4_INIT;
            r_first     <= 1'b0;
            r_in_pad    <= 1'b0;
            r_len_blk   <= 1'b0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_h0        <= n_h0;
            r_h1        <= n_h1;
            r_h2        <= n_h2;
            r_h3        <= n_h3;
            r_h4        <= n_h4;
            r_first     <= n_first;
            r_in_pad    <= n_in_pad;
            r_len_blk   <= n_len_blk;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
        end
    end

    // Working words and digest payload carry no reset
    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_c <= n_c;
        r_d <= n_d;
        r_e <= n_e;
        if (n_dig_load) begin
            r_dig0 <= r_h0;
            r_dig1 <= r_h1;
            r_dig2 <= r_h2;
            r_dig3 <= r_h3;
            r_dig4 <= r_h4;
        end
    end

    // Take a transaction only while idle; the digest sits in its own register
    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_digest_word0 = r_dig0;
    assign o_digest_word1 = r_dig1;
    assign o_digest_word2 = r_dig2;
    assign o_digest_word3 = r_dig3;
    assign o_digest_word4 = r_dig4;

endmodule

[sv/s1md_checker.sv]
module s1md_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [7:0]  i_data_byte,
    input logic        i_has_byte,
    input logic        i_end_of_message,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_digest_word0,
    input logic [31:0] o_digest_word1,
    input logic [31:0] o_digest_word2,
    input logic [31:0] o_digest_word3,
    input logic [31:0] o_digest_word4
);

    // A stalled digest holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_digest_word0)
            && $stable(o_digest_word1) && $stable(o_digest_word2)
            && $stable(o_digest_word3) && $stable(o_digest_word4))
        else $error("digest changed while stalled");

    // A stalled input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_data_byte)
            && $stable(i_has_byte) && $stable(i_end_of_message))
        else $error("input changed while stalled");

    // Closing a message always makes the unit busy with padding or compression
    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_end_of_message |=> o_in_stall)
        else $error("no padding after end of message");

    // An empty transaction leaves the unit idle
    a_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_has_byte && !i_end_of_message |=> !o_in_stall)
        else $error("empty transaction made the unit busy");

    // A new digest appears only at the end of busy work
    a_digest_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("digest without a finished message");

endmodule

bind sha1_message_digest_unit s1md_checker u_s1md_checker (.*);

[tb/sv/sha1_message_digest_unit_test.sv]
module sha1_message_digest_unit_test;
    import s1md_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Give up after this many cycles in which neither channel completes a transaction.
    // The limit sits well above both the slowest close (pad, overflow block, two compressions)
    // and the long receiver hold-off below, so it leaves a wide margin.
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 1000;
    localparam int DRAIN_CYCLES = 400;
    localparam int RANDOM_ITEMS = 2000;

    // One input transaction: byte, byte-present flag, end-of-message flag
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       eom;
    } msg_item_t;

    // Digest words, index 0 being the most significant word
    typedef logic [0:4][31:0] digest_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_has_byte = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_digest_word0;
    logic [31:0] o_digest_word1;
    logic [31:0] o_digest_word2;
    logic [31:0] o_digest_word3;
    logic [31:0] o_digest_word4;

    sha1_message_digest_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_digest_word0   (o_digest_word0),
        .o_digest_word1   (o_digest_word1),
        .o_digest_word2   (o_digest_word2),
        .o_digest_word3   (o_digest_word3),
        .o_digest_word4   (o_digest_word4)
    );

    always #2 i_clk = ~i_clk;

    // Stimulus waiting to be driven, and digests waiting to arrive
    msg_item_t byte_stream_q[$];
    digest_t   digest_expected_q[$];

    int n_real = 0;     // queued transactions that are not pure idles
    int n_total = 0;    // everything queued, fixed before reset is released
    int n_sent = 0;     // transactions put on the input port so far
    int n_fail = 0;
    logic item_taken = 1'b0;   // input transaction completed at the last rising edge

    // ------------------------------------------------------------------
    // Digest predictor: own copy of the chaining words, block and count
    // ------------------------------------------------------------------
    logic [31:0] sha_chain [5];
    logic [7:0]  sha_blk [64];
    logic [60:0] sha_len;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic sha_restart();
        sha_chain[0] = H0_INIT;
        sha_chain[1] = H1_INIT;
        sha_chain[2] = H2_INIT;
        sha_chain[3] = H3_INIT;
        sha_chain[4] = H4_INIT;
        sha_len = '0;
    endtask

    // Run the 80 rounds over the block buffer and fold the result into the chain
    task automatic sha_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, sum;
        int t;
        for (t = 0; t < 16; t++)
            w[t] = {sha_blk[4*t], sha_blk[4*t+1], sha_blk[4*t+2], sha_blk[4*t+3]};
        a = sha_chain[0];
        b = sha_chain[1];
        c = sha_chain[2];
        d = sha_chain[3];
        e = sha_chain[4];
        for (t = 0; t < 80; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                wt = rotl(w[(t+13) & 15] ^ w[(t+8) & 15] ^ w[(t+2) & 15] ^ w[t & 15], 1);
                w[t & 15] = wt;
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K_R0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_R1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_R2;
            end else begin
                f = b ^ c ^ d;
                k = K_R3;
            end
            sum = rotl(a, 5) + f + e + k + wt;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = sum;
        end
        sha_chain[0] = sha_chain[0] + a;
        sha_chain[1] = sha_chain[1] + b;
        sha_chain[2] = sha_chain[2] + c;
        sha_chain[3] = sha_chain[3] + d;
        sha_chain[4] = sha_chain[4] + e;
    endtask

    // Take one accepted transaction; on end of message, pad and queue the digest
    task automatic sha_absorb(input msg_item_t it);
        int pos;
        int i;
        logic [63:0] bits;
        digest_t dg;
        if (it.has) begin
            sha_blk[sha_len[5:0]] = it.data;
            sha_len = sha_len + 1'b1;
            if (sha_len[5:0] == 6'd0)
                sha_compress();
        end
        if (it.eom) begin
            pos = int'(sha_len[5:0]);
            sha_blk[pos] = PAD_BYTE;
            pos++;
            // No room left for the length: close this block and open an extra one
            if (pos > 56) begin
                while (pos < 64) begin
                    sha_blk[pos] = 8'h00;
                    pos++;
                end
                sha_compress();
                pos = 0;
            end
            while (pos < 56) begin
                sha_blk[pos] = 8'h00;
                pos++;
            end
            bits = {sha_len, 3'b000};
            for (i = 0; i < 8; i++)
                sha_blk[56+i] = bits[63-8*i -: 8];
            sha_compress();
            dg = {sha_chain[0], sha_chain[1], sha_chain[2], sha_chain[3], sha_chain[4]};
            digest_expected_q.push_back(dg);
            sha_restart();
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic push_item(input logic [7:0] data, input logic has, input logic eom);
        msg_item_t it;
        it.data = data;
        it.has = has;
        it.eom = eom;
        byte_stream_q.push_back(it);
        if (has || eom)
            n_real++;
    endtask

    // Queue a whole message of random bytes, with the odd idle transaction mixed in.
    // Close either on the last byte or with a separate empty closing transaction.
    task automatic queue_message(input int n_bytes, input bit close_on_byte);
        int j;
        for (j = 0; j < n_bytes; j++) begin
            if ($urandom_range(0, 99) < 5)
                push_item(8'($urandom), 1'b0, 1'b0);
            push_item(8'($urandom), 1'b1, close_on_byte && (j == n_bytes - 1));
        end
        if (!close_on_byte || n_bytes == 0)
            push_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // Choose a message length: mostly short, often right around the padding boundaries
    function automatic int pick_length();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return $urandom_range(0, 20);
        else if (sel < 8)
            return $urandom_range(52, 68);
        else if (sel == 8)
            return $urandom_range(116, 132);
        else
            return $urandom_range(0, 200);
    endfunction

    // Idle percentage for the current phase: sender-light, then sender-heavy, then none
    function automatic int idle_pct(input bit sender_side);
        int phase;
        phase = (n_total == 0) ? 0 : (n_sent * 3) / n_total;
        if (phase == 0)
            return sender_side ? 20 : 60;
        else if (phase == 1)
            return sender_side ? 60 : 20;
        else
            return 0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: present the next transaction once the current one has gone
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_input
        msg_item_t nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || item_taken) begin
            // Slot is free: either load the next transaction or idle
            if (byte_stream_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
                nxt = byte_stream_q.pop_front();
                i_in_valid       <= 1'b1;
                i_data_byte      <= nxt.data;
                i_has_byte       <= nxt.has;
                i_end_of_message <= nxt.eom;
                n_sent           <= n_sent + 1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        // Otherwise hold the stalled transaction unchanged
    end

    // ------------------------------------------------------------------
    // Receiver: random stall, plus one long hold-off half way through
    // ------------------------------------------------------------------
    int  hold_left = 0;
    logic hold_done = 1'b0;

    always @(negedge i_clk) begin : drive_output_stall
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (i_rst_n && !hold_done && n_total != 0 && n_sent >= n_total / 2) begin
            // Keep feeding the input meanwhile, so the block backs up and stalls it
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < idle_pct(1'b0));
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each digest transaction, predict from each input one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        digest_t got;
        digest_t want;
        msg_item_t seen;
        int i;
        if (!i_rst_n) begin
            item_taken <= 1'b0;
        end else begin
            item_taken <= i_in_valid && !o_in_stall;
            if (o_out_valid && !i_out_stall) begin
                got = {o_digest_word0, o_digest_word1, o_digest_word2,
                       o_digest_word3, o_digest_word4};
                if (digest_expected_q.size() == 0) begin
                    $display("%0t: unexpected digest, expected none, actual %h", $time, got);
                    n_fail++;
                end else begin
                    want = digest_expected_q.pop_front();
                    for (i = 0; i < 5; i++) begin
                        if (got[i] !== want[i]) begin
                            $display("%0t: digest_word%0d expected %h actual %h",
                                     $time, i, want[i], got[i]);
                            n_fail++;
                        end
                    end
                end
            end
            // A digest cannot leave in the cycle its closing byte arrives,
            // so predicting after the check keeps the order right
            if (i_in_valid && !o_in_stall) begin
                seen.data = i_data_byte;
                seen.has  = i_has_byte;
                seen.eom  = i_end_of_message;
                sha_absorb(seen);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles in which no transaction completes on either side
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence: build the stimulus, release reset, drain and report
    // ------------------------------------------------------------------
    initial begin : sequencer
        int len;
        sha_restart();

        // Directed: empty messages back to back, ignored data at both extremes
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'hFF, 1'b0, 1'b1);
        // Closing on a byte: "abc"
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h63, 1'b1, 1'b1);
        // Single zero byte that also ends its message
        push_item(8'h00, 1'b1, 1'b1);
        // All-ones byte, an ignored idle, then an empty closing transaction
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'h5A, 1'b0, 1'b1);
        // Idle ahead of a message, and a byte equal to the pad value
        push_item(8'hA5, 1'b0, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'h80, 1'b1, 1'b1);

        // Random messages until enough real transactions are queued
        while (n_real < RANDOM_ITEMS + 12) begin
            len = pick_length();
            queue_message(len, 1'($urandom_range(0, 1)));
        end
        n_total = byte_stream_q.size();

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last input transaction to go, then for every digest
        while (byte_stream_q.size() != 0 || i_in_valid)
            @(negedge i_clk);
        while (digest_expected_q.size() != 0)
            @(posedge i_clk);
        // Leave room for any stray digest to show up
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (digest_expected_q.size() != 0) begin
            $display("%0t: missing digest, expected %0d more, actual none", $time,
                     digest_expected_q.size());
            n_fail++;
        end

        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
